### rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared constants, types and helper functions of the letter frequency ranker.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int NUM_LETTERS = 29;
    localparam int COUNT_BITS  = 32;
    localparam int ALPHA_SIZE  = 29;
    localparam int OUT_BITS    = 32;
    localparam int LIM_LETTERS = (NUM_LETTERS < ALPHA_SIZE) ? NUM_LETTERS : ALPHA_SIZE;
    localparam int IDX_W       = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 80;
    localparam int CFG_ADDR_W  = 3;

    localparam logic CFG_IDX_FOLD = 1'b0;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    localparam count_t COUNT_MAX = '1;

    typedef struct packed {
        logic last;
        logic hit;
        idx_t idx;
    } item_t;

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_WALK,
        ST_REPORT
    } back_state_t;

    localparam logic [7:0] ALPHA_CODES [ALPHA_SIZE] = '{
        8'h41, 8'h42, 8'h43, 8'hC7, 8'h44, 8'h45, 8'h46, 8'h47, 8'hD0, 8'h48,
        8'h49, 8'hDD, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'hD6, 8'h50,
        8'h52, 8'h53, 8'hDE, 8'h54, 8'h55, 8'hDC, 8'h56, 8'h59, 8'h5A
    };

    localparam logic [7:0] CH_LOWER_A     = 8'h61;
    localparam logic [7:0] CH_LOWER_Z     = 8'h7A;
    localparam logic [7:0] CH_LOWER_I     = 8'h69;
    localparam logic [7:0] CH_CAP_I       = 8'h49;
    localparam logic [7:0] CH_CAP_DOT_I   = 8'hDD;
    localparam logic [7:0] CH_DOTLESS_I   = 8'hFD;
    localparam logic [7:0] CH_LOW_C_CED   = 8'hE7;
    localparam logic [7:0] CH_CAP_C_CED   = 8'hC7;
    localparam logic [7:0] CH_LOW_G_BRV   = 8'hF0;
    localparam logic [7:0] CH_CAP_G_BRV   = 8'hD0;
    localparam logic [7:0] CH_LOW_O_UML   = 8'hF6;
    localparam logic [7:0] CH_CAP_O_UML   = 8'hD6;
    localparam logic [7:0] CH_LOW_S_CED   = 8'hFE;
    localparam logic [7:0] CH_CAP_S_CED   = 8'hDE;
    localparam logic [7:0] CH_LOW_U_UML   = 8'hFC;
    localparam logic [7:0] CH_CAP_U_UML   = 8'hDC;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic turkish);
        logic [7:0] r;
        r = b;
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
        begin
            if (turkish && b == CH_LOWER_I)
                r = CH_CAP_DOT_I;
            else
                r = b - CASE_OFFSET;
        end
        else if (turkish)
        begin
            case (b)
                CH_DOTLESS_I: r = CH_CAP_I;
                CH_LOW_C_CED: r = CH_CAP_C_CED;
                CH_LOW_G_BRV: r = CH_CAP_G_BRV;
                CH_LOW_O_UML: r = CH_CAP_O_UML;
                CH_LOW_S_CED: r = CH_CAP_S_CED;
                CH_LOW_U_UML: r = CH_CAP_U_UML;
                default:      r = b;
            endcase
        end
        return r;
    endfunction

    // Bins beyond the alphabet report a zero code
    function automatic logic [7:0] letter_code_of(input idx_t idx);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < ALPHA_SIZE; k++)
        begin
            if (32'(idx) == k)
                r = ALPHA_CODES[k];
        end
        return r;
    endfunction

endpackage

### rtl/letter_frequency_ranker.sv
// ----------------------------------------------------------------------------
// letter_frequency_ranker
// Turkish letter histogram over Windows-1254 text with a ranked report.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: char_byte; tlast: end_of_text
//  m_axis   | out       | tdata: code, index, count, total, saturated; tlast
//  apb      | in/out    | reg 0 at 0x0: turkish_case_fold
//
//  Counting: a byte a cycle between reports, set by the single bin update port.
//  A report walks every bin, then sends NUM_LETTERS output transactions.
//  Input still fills the four-entry queue while the report runs.
//  Reset clears bins, flags and queue at once; no clearing pass.
//  Either side may stall freely; the output register holds until taken.
// ----------------------------------------------------------------------------
module letter_frequency_ranker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfr_pkg::TDATA_IN_W-1:0]    s_tdata,  // [7:0] char_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] letter_code, [12:8] letter_index, [44:13] letter_count,
    // [76:45] total_count, [77] count_saturated, [79:78] zero
    output logic [lfr_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import lfr_pkg::*;

    logic  fold_reg;
    item_t front_item;
    item_t queue_item;
    logic  queue_full;
    logic  queue_valid;
    logic  queue_pop;
    logic  reg_sel;

    assign pready   = 1'b1;
    assign reg_sel  = (paddr[2] == CFG_IDX_FOLD);
    assign prdata   = reg_sel ? {31'b0, fold_reg} : 32'b0;
    assign s_tready = !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && reg_sel)
            fold_reg <= pwdata[0];
    end

    lfr_front u_front (
        .turkish_case_fold (fold_reg),
        .char_byte         (s_tdata),
        .end_of_text       (s_tlast),
        .item              (front_item)
    );

    lfr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .not_empty (queue_valid)
    );

    lfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_pop   (queue_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### rtl/lfr_front.sv
// ----------------------------------------------------------------------------
// lfr_front
// Folds each byte to upper case and maps it to a letter bin, if it is one.
// ----------------------------------------------------------------------------
module lfr_front (
    input  logic              turkish_case_fold,
    input  logic [7:0]        char_byte,
    input  logic              end_of_text,
    output lfr_pkg::item_t    item
);
    import lfr_pkg::*;

    logic [7:0] folded;

    always_comb
    begin
        folded    = fold_byte(char_byte, turkish_case_fold);
        item.last = end_of_text;
        item.hit  = 1'b0;
        item.idx  = '0;
        for (int k = 0; k < LIM_LETTERS; k++)
        begin
            if (folded == ALPHA_CODES[k])
            begin
                item.hit = 1'b1;
                item.idx = IDX_W'(k);
            end
        end
    end

endmodule

### rtl/lfr_fifo.sv
// ----------------------------------------------------------------------------
// lfr_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module lfr_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lfr_pkg::item_t    push_item,
    output logic              full,
    input  logic              pop,
    output lfr_pkg::item_t    pop_item,
    output logic              not_empty
);
    import lfr_pkg::*;

    item_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   fill_reg;
    logic [FIFO_PTR_W:0]   fill_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (fill_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (!do_push && do_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/lfr_back.sv
// ----------------------------------------------------------------------------
// lfr_back
// Letter bins with saturating counts, rank walk and ranked report output.
// ----------------------------------------------------------------------------
module lfr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfr_pkg::item_t                item,
    input  logic                          item_valid,
    output logic                          item_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lfr_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import lfr_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    count_t bins_reg [NUM_LETTERS];
    idx_t   rank_reg [NUM_LETTERS];
    count_t total_reg;
    logic   tot_sat_reg;
    logic   sat_seen_reg;
    idx_t   walk_reg;
    idx_t   pos_reg;

    logic                   m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    idx_t                rd_idx;
    count_t              c_rd;
    idx_t                sel_idx;
    logic [COUNT_BITS:0] tot_sum;
    logic                walk_done;
    logic                rep_load;
    logic                rep_done;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < NUM_LETTERS; i++)
        begin
            if (rank_reg[i] == pos_reg)
                sel_idx = IDX_W'(i);
        end
    end

    // Shared read port into the bins; the walk's rank compare reads all bins
    always_comb
    begin
        case (state_reg)
            ST_COUNT:  rd_idx = item.idx;
            ST_WALK:   rd_idx = walk_reg;
            ST_REPORT: rd_idx = sel_idx;
            default:   rd_idx = '0;
        endcase
        c_rd = '0;
        if (32'(rd_idx) < NUM_LETTERS)
            c_rd = bins_reg[rd_idx];
    end

    assign tot_sum   = {1'b0, total_reg} + {1'b0, c_rd};
    assign walk_done = (walk_reg == IDX_W'(NUM_LETTERS - 1));
    assign rep_done  = (pos_reg == IDX_W'(NUM_LETTERS - 1));

    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        rep_load   = 1'b0;
        case (state_reg)
            ST_COUNT:
            begin
                item_pop = item_valid;
                if (item_valid && item.last)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_done)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                rep_load = !m_tvalid_reg || m_tready;
                if (rep_load && rep_done)
                    state_next = ST_COUNT;
            end
            default:
                state_next = ST_COUNT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_COUNT;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LETTERS; i++)
            begin
                bins_reg[i] <= '0;
                rank_reg[i] <= '0;
            end
            total_reg    <= '0;
            tot_sat_reg  <= 1'b0;
            sat_seen_reg <= 1'b0;
            walk_reg     <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (rep_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_COUNT:
                begin
                    if (item_valid)
                    begin
                        if (item.hit)
                        begin
                            if (c_rd == COUNT_MAX)
                                sat_seen_reg <= 1'b1;
                            else
                                bins_reg[item.idx] <= c_rd + 1'b1;
                        end
                        walk_reg  <= '0;
                        total_reg <= '0;
                    end
                end
                ST_WALK:
                begin
                    if (tot_sum[COUNT_BITS])
                    begin
                        total_reg   <= COUNT_MAX;
                        tot_sat_reg <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= tot_sum[COUNT_BITS-1:0];
                    end
                    for (int i = 0; i < NUM_LETTERS; i++)
                    begin
                        if (c_rd > bins_reg[i] ||
                            (c_rd == bins_reg[i] && walk_reg < IDX_W'(i)))
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                    walk_reg <= walk_reg + 1'b1;
                    pos_reg  <= '0;
                end
                ST_REPORT:
                begin
                    if (rep_load)
                    begin
                        m_tlast_reg  <= rep_done;
                        pos_reg      <= pos_reg + 1'b1;
                        if (rep_done)
                        begin
                            for (int i = 0; i < NUM_LETTERS; i++)
                            begin
                                bins_reg[i] <= '0;
                                rank_reg[i] <= '0;
                            end
                            total_reg    <= '0;
                            tot_sat_reg  <= 1'b0;
                            sat_seen_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rep_load)
            m_tdata_reg <= {2'b00,
                            sat_seen_reg | tot_sat_reg,
                            OUT_BITS'(total_reg),
                            OUT_BITS'(c_rd),
                            5'(sel_idx),
                            letter_code_of(sel_idx)};
    end

endmodule

### bench/letter_frequency_ranker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_frequency_ranker_tb
// Feeds Windows-1254 text through the ranker with random stalls on both
// streams, save the last phase. Letter tallies are kept beside the block;
// every report is ranked here and compared per transaction with m_axis.
// ----------------------------------------------------------------------------
module letter_frequency_ranker_tb;

    import lfr_pkg::*;

    localparam int BOGUS_REG_IDX = 1;
    localparam int SETTLE_CYCLES = 2 * NUM_LETTERS + 8;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef struct {
        logic [7:0]  code;
        logic [4:0]  idx;
        logic [31:0] cnt;
        logic [31:0] total;
        logic        sat;
        logic        last;
    } rank_entry_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata = '0;   // [7:0] char_byte
    logic                    s_tlast = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [7:0] letter_code, [12:8] letter_index, [44:13] letter_count,
    // [76:45] total_count, [77] count_saturated, [79:78] zero
    logic [TDATA_OUT_W-1:0]  m_tdata;
    logic                    m_tlast;

    text_item_t  text_q[$];
    rank_entry_t ranking_q[$];
    count_t      letter_tally[NUM_LETTERS];
    logic        tally_clipped = 1'b0;
    logic        fold_mode = 1'b1;
    logic        no_idle = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          mismatches = 0;
    int          items_queued = 0;
    text_item_t  tx_next;
    rank_entry_t got;
    rank_entry_t want;

    letter_frequency_ranker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] upcase_1254(input logic [7:0] b, input logic tr);
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
            return (tr && b == CH_LOWER_I) ? CH_CAP_DOT_I : b - CASE_OFFSET;
        if (!tr)
            return b;
        case (b)
            CH_DOTLESS_I: return CH_CAP_I;
            CH_LOW_C_CED: return CH_CAP_C_CED;
            CH_LOW_G_BRV: return CH_CAP_G_BRV;
            CH_LOW_O_UML: return CH_CAP_O_UML;
            CH_LOW_S_CED: return CH_CAP_S_CED;
            CH_LOW_U_UML: return CH_CAP_U_UML;
            default:      return b;
        endcase
    endfunction

    function automatic logic [7:0] bin_code(input int k);
        return (k < ALPHA_SIZE) ? ALPHA_CODES[k] : 8'h00;
    endfunction

    // Count one byte; on end of text rank all bins and queue the report
    task automatic tally_and_rank(input logic [7:0] raw, input logic eot);
        logic [7:0]  up;
        count_t      total;
        logic        sat;
        int          rank;
        rank_entry_t slot[NUM_LETTERS];
        up = upcase_1254(raw, fold_mode);
        for (int k = 0; k < LIM_LETTERS; k++)
        begin
            if (bin_code(k) == up)
            begin
                if (letter_tally[k] == COUNT_MAX)
                    tally_clipped = 1'b1;
                else
                    letter_tally[k] = letter_tally[k] + 1'b1;
            end
        end
        if (!eot)
            return;
        total = '0;
        sat = tally_clipped;
        for (int k = 0; k < NUM_LETTERS; k++)
        begin
            if (letter_tally[k] > COUNT_MAX - total)
            begin
                total = COUNT_MAX;
                sat = 1'b1;
            end
            else
                total = total + letter_tally[k];
        end
        for (int k = 0; k < NUM_LETTERS; k++)
        begin
            rank = 0;
            for (int j = 0; j < NUM_LETTERS; j++)
                if (letter_tally[j] > letter_tally[k] ||
                    (letter_tally[j] == letter_tally[k] && j < k))
                    rank++;
            slot[rank].code  = bin_code(k);
            slot[rank].idx   = 5'(k);
            slot[rank].cnt   = 32'(letter_tally[k]);
            slot[rank].total = 32'(total);
            slot[rank].sat   = sat;
            slot[rank].last  = (rank == NUM_LETTERS - 1);
        end
        for (int r = 0; r < NUM_LETTERS; r++)
            ranking_q.push_back(slot[r]);
        for (int k = 0; k < NUM_LETTERS; k++)
            letter_tally[k] = '0;
        tally_clipped = 1'b0;
    endtask

    // Text source
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                tally_and_rank(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (text_q.size() > 0)
                begin
                    tx_next = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_next.ch;
                    s_tlast  <= tx_next.eot;
                    if (!no_idle && $urandom_range(0, 3) == 0)
                        tx_gap = $urandom_range(1, 7);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Report sink and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.code  = m_tdata[7:0];
                got.idx   = m_tdata[12:8];
                got.cnt   = m_tdata[44:13];
                got.total = m_tdata[76:45];
                got.sat   = m_tdata[77];
                got.last  = m_tlast;
                if (ranking_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: code %h idx %0d cnt %0d",
                                 got.code, got.idx, got.cnt);
                end
                else
                begin
                    want = ranking_q.pop_front();
                    if (got.code !== want.code || got.idx !== want.idx ||
                        got.cnt !== want.cnt || got.total !== want.total ||
                        got.sat !== want.sat || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%0d/%0d/%0d/%b/%b got %h/%0d/%0d/%0d/%b/%b",
                                     want.code, want.idx, want.cnt, want.total, want.sat,
                                     want.last, got.code, got.idx, got.cnt, got.total,
                                     got.sat, got.last);
                    end
                end
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    rx_gap = $urandom_range(1, 7);
            end
        end
    end

    task automatic put_byte(input logic [7:0] ch, input logic eot);
        text_item_t it;
        it.ch  = ch;
        it.eot = eot;
        text_q.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return 8'($urandom_range(0, 255));
        if (sel < 6)
            return ALPHA_CODES[$urandom_range(0, ALPHA_SIZE - 1)];
        if (sel < 9)
            return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        case ($urandom_range(0, 5))
            0:       return CH_DOTLESS_I;
            1:       return CH_LOW_C_CED;
            2:       return CH_LOW_G_BRV;
            3:       return CH_LOW_O_UML;
            4:       return CH_LOW_S_CED;
            default: return CH_LOW_U_UML;
        endcase
    endfunction

    task automatic put_text(input int len);
        for (int k = 0; k < len; k++)
            put_byte(pick_byte(), k == len - 1);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_q.size() != 0 || s_tvalid || ranking_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input int idx, input logic wr, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!wr && prdata !== 32'(fold_mode))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register read: exp %h got %h", 32'(fold_mode), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (wr && idx == int'(CFG_IDX_FOLD))
            fold_mode = val[0];
    endtask

    task automatic set_fold(input logic tr);
        apb_access(int'(CFG_IDX_FOLD), 1'b1, {31'($urandom_range(0, 32'h7fffffff)), tr});
        apb_access(int'(CFG_IDX_FOLD), 1'b0, '0);
    endtask

    initial
    begin
        int phase_start;
        logic [7:0] turkish_mix[15];
        for (int k = 0; k < NUM_LETTERS; k++)
            letter_tally[k] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Turkish folding out of reset: case pairs, non-letters, byte extremes
        turkish_mix = '{8'h61, CH_LOWER_I, CH_DOTLESS_I, CH_LOW_C_CED, CH_LOW_G_BRV,
                        CH_LOW_O_UML, CH_LOW_S_CED, CH_LOW_U_UML, 8'h7A, 8'h51,
                        8'h77, 8'h30, 8'h00, 8'hFF, 8'h5A};
        foreach (turkish_mix[k])
            put_byte(turkish_mix[k], k == 14);
        // empty report: every count zero, alphabet order
        put_byte(8'h80, 1'b1);
        wait_idle();

        // plain ASCII folding; a write to an unknown register changes nothing
        set_fold(1'b0);
        apb_access(BOGUS_REG_IDX, 1'b1, 32'hFFFF_FFFF);
        apb_access(int'(CFG_IDX_FOLD), 1'b0, '0);
        put_byte(CH_LOWER_I, 1'b0);
        put_byte(CH_DOTLESS_I, 1'b0);
        put_byte(CH_LOW_C_CED, 1'b0);
        put_byte(CH_CAP_DOT_I, 1'b0);
        put_byte(CH_CAP_C_CED, 1'b0);
        put_byte(CH_LOW_U_UML, 1'b0);
        put_byte(8'h41, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            set_fold(ph % 2 == 0);
            no_idle = (ph == 4);
            phase_start = items_queued;
            while (items_queued - phase_start < 56)
                put_text(($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                     : $urandom_range(1, 20));
            wait_idle();
        end

        if (mismatches == 0)
            $display("letter_frequency_ranker_tb OK");
        else
            $display("letter_frequency_ranker_tb NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("letter_frequency_ranker_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/lfr_pkg.sv
rtl/lfr_front.sv
rtl/lfr_fifo.sv
rtl/lfr_back.sv
rtl/letter_frequency_ranker.sv
bench/letter_frequency_ranker_tb.sv
